>>> rtl/nine_bit_alarm_datagram_decoder_top_defines.svh
// Assertion macros for the alarm datagram decoder.
`ifndef NINE_BIT_ALARM_DATAGRAM_DECODER_TOP_DEFINES_SVH
`define NINE_BIT_ALARM_DATAGRAM_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define NBAD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define NBAD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/nbad_pkg.sv
// Types and pattern constants shared by the alarm datagram decoder.
package nbad_pkg;

    localparam int HEAD_LEN = 10;

    localparam logic [7:0] MOB_ON_ID      = 8'h67;
    localparam logic [7:0] MOB_ON_SUB_A   = 8'h77;
    localparam logic [7:0] MOB_ON_SUB_B   = 8'h07;
    localparam logic [7:0] MOB_CANCEL_ID  = 8'h36;
    localparam logic [7:0] MOB_CANCEL_ARG = 8'h01;
    localparam logic [7:0] RADAR_ID_A     = 8'hA8;
    localparam logic [7:0] RADAR_ID_B     = 8'hAB;
    localparam logic [7:0] RADAR_SUB_A    = 8'h43;
    localparam logic [7:0] RADAR_SUB_B    = 8'h53;
    localparam logic [7:0] RADAR_ARG      = 8'h80;
    localparam logic [7:0] RADAR_ON_CODE  = 8'hD3;
    localparam logic [7:0] RADAR_OFF_CODE = 8'hC3;
    localparam logic [7:0] WIND_ID        = 8'h66;
    localparam logic [7:0] ZERO_BYTE      = 8'h00;

    typedef logic [HEAD_LEN-1:0][7:0] head_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       command_flag;
    } in_item_t;

    typedef struct packed {
        logic mob_alarm;
        logic wind_alarm;
        logic radar_alarm;
        logic snooze_clear;
        logic datagram_done;
    } out_item_t;

    typedef struct packed {
        logic mob_on;
        logic mob_cancel;
        logic radar_on;
        logic radar_off;
        logic wind_on;
        logic wind_off;
    } match_t;

endpackage

>>> rtl/nbad_matcher.sv
// Pattern matcher over the first slots of the datagram buffer.
module nbad_matcher
    import nbad_pkg::*;
(
    input  head_t  head,
    output match_t match
);

    logic mob_tail_zero;
    logic radar_hdr;
    logic wind_hdr;

    always_comb
    begin
        mob_tail_zero = 1'b1;
        for (int i = 2; i < HEAD_LEN; i++)
        begin
            if (head[i] != ZERO_BYTE)
            begin
                mob_tail_zero = 1'b0;
            end
        end

        radar_hdr = (head[0] == RADAR_ID_A || head[0] == RADAR_ID_B)
                 && (head[1] == RADAR_SUB_A || head[1] == RADAR_SUB_B)
                 && head[2] == RADAR_ARG && head[3] == ZERO_BYTE
                 && head[4] == ZERO_BYTE;
        wind_hdr  = head[0] == WIND_ID && head[1] == ZERO_BYTE;

        match.mob_on     = head[0] == MOB_ON_ID
                        && (head[1] == MOB_ON_SUB_A || head[1] == MOB_ON_SUB_B)
                        && mob_tail_zero;
        match.mob_cancel = head[0] == MOB_CANCEL_ID && head[1] == ZERO_BYTE
                        && head[2] == MOB_CANCEL_ARG;
        match.radar_on   = radar_hdr && head[5] == RADAR_ON_CODE;
        match.radar_off  = radar_hdr && head[5] == RADAR_OFF_CODE;
        match.wind_on    = wind_hdr && head[2] != ZERO_BYTE;
        match.wind_off   = wind_hdr && head[2] == ZERO_BYTE;
    end

endmodule

>>> rtl/nbad_frame_buf.sv
// Datagram byte buffer with saturating write position.
module nbad_frame_buf
    import nbad_pkg::*;
#(
    parameter int DEPTH = 20
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  logic       restart,
    input  logic [7:0] data,
    output head_t      head
);

    localparam int PosW = $clog2(DEPTH);
    localparam logic [PosW-1:0] LastPos = PosW'(DEPTH - 1);

    logic [DEPTH-1:0][7:0] slot_reg;
    logic [PosW-1:0]       pos_reg;
    logic [PosW-1:0]       pos_next;
    logic [PosW-1:0]       wr_pos;

    always_comb
    begin
        wr_pos   = restart ? '0 : pos_reg;
        pos_next = (wr_pos == LastPos) ? wr_pos : wr_pos + 1'b1;
        for (int i = 0; i < HEAD_LEN; i++)
        begin
            head[i] = slot_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            pos_reg  <= '0;
        end
        else if (wr_en)
        begin
            slot_reg[wr_pos] <= data;
            pos_reg          <= pos_next;
        end
    end

endmodule

>>> rtl/nine_bit_alarm_datagram_decoder_top.sv
// An accepted item waits in the input register, and its result is loaded into the result register
// when the item advances; out_data shows the result register.
// Throughput: one item per cycle unless the result side stalls; input and result registers decouple the ports.
// The command byte match reads buffer slots 0..9 and updates flags in the same cycle.
// Reset clears the buffer, write position, alarm flags and both valid registers.
`include "nine_bit_alarm_datagram_decoder_top_defines.svh"
module nine_bit_alarm_datagram_decoder_top
    import nbad_pkg::*;
#(
    parameter int BUFFER_DEPTH = 20
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    logic      in_vld_reg;
    logic      in_vld_next;
    in_item_t  in_item_reg;
    logic      out_vld_reg;
    logic      out_vld_next;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    logic      mob_reg;
    logic      mob_next;
    logic      wind_reg;
    logic      wind_next;
    logic      radar_reg;
    logic      radar_next;
    logic      advance;
    logic      cmd;
    head_t     head;
    match_t    match;

    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign cmd      = in_item_reg.command_flag;

    nbad_frame_buf #(
        .DEPTH (BUFFER_DEPTH)
    ) u_frame_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (advance),
        .restart (cmd),
        .data    (in_item_reg.rx_byte),
        .head    (head)
    );

    nbad_matcher u_matcher (
        .head  (head),
        .match (match)
    );

    always_comb
    begin
        mob_next   = mob_reg;
        wind_next  = wind_reg;
        radar_next = radar_reg;
        if (cmd)
        begin
            if (match.mob_on)
            begin
                mob_next = 1'b1;
            end
            if (match.mob_cancel)
            begin
                mob_next = 1'b0;
            end
            if (match.radar_on)
            begin
                radar_next = 1'b1;
            end
            if (match.radar_off)
            begin
                radar_next = 1'b0;
            end
            if (match.wind_on)
            begin
                wind_next = 1'b1;
            end
            if (match.wind_off)
            begin
                wind_next = 1'b0;
            end
        end

        out_item_next.mob_alarm     = mob_next;
        out_item_next.wind_alarm    = wind_next;
        out_item_next.radar_alarm   = radar_next;
        out_item_next.snooze_clear  = cmd && (match.radar_on || match.wind_on);
        out_item_next.datagram_done = cmd;

        if (in_valid && !in_stall)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
        else
        begin
            in_vld_next = in_vld_reg;
        end

        if (advance)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_vld_reg && !out_stall)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            mob_reg     <= 1'b0;
            wind_reg    <= 1'b0;
            radar_reg   <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance)
            begin
                mob_reg   <= mob_next;
                wind_reg  <= wind_next;
                radar_reg <= radar_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_item_reg;

    `NBAD_ASSERT_IMPL(a_snooze_on_done, out_vld_reg && out_item_reg.snooze_clear, out_item_reg.datagram_done, "snooze without datagram evaluation")
    `NBAD_ASSERT_IMPL(a_snooze_flag, out_vld_reg && out_item_reg.snooze_clear, out_item_reg.wind_alarm || out_item_reg.radar_alarm, "snooze without alarm set")
    `NBAD_ASSERT_NEXT(a_advance_fills, advance, out_vld_reg && out_item_reg.mob_alarm == mob_reg, "result register not loaded")

endmodule

>>> tb/nine_bit_alarm_datagram_decoder_checker.sv
// Alarm decoder checker: tracks the decoder state per accepted item and compares every result.
module nine_bit_alarm_datagram_decoder_checker
    import nbad_pkg::*;
#(
    parameter int BUFFER_DEPTH = 20
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_data,
    output int        fail_count,
    output int        pending
);

    logic [7:0]  frame_buf [BUFFER_DEPTH];
    int unsigned wr_pos;
    logic        mob_flag;
    logic        wind_flag;
    logic        radar_flag;
    out_item_t   expected_alarms_q [$];
    int          errors = 0;

    assign fail_count = errors;
    assign pending    = expected_alarms_q.size();

    task automatic report_mismatch(input string msg);
        begin
            if (errors < 40)
                $display("%0t: %s", $time, msg);
            errors++;
        end
    endtask

    task automatic check_flag(input string name, input logic got, input logic want);
        begin
            if (got !== want)
                report_mismatch($sformatf("%s is %b, expected %b", name, got, want));
        end
    endtask

    // Match the buffered datagram head; returns 1 when a snooze pulse is due.
    function automatic logic match_datagram();
        logic snooze;
        logic tail_zero;
        int   i;
        begin
            snooze = 1'b0;
            case (frame_buf[0])
                MOB_ON_ID:
                begin
                    tail_zero = 1'b1;
                    for (i = 2; i < HEAD_LEN; i++)
                        if (frame_buf[i] != ZERO_BYTE)
                            tail_zero = 1'b0;
                    if ((frame_buf[1] == MOB_ON_SUB_A || frame_buf[1] == MOB_ON_SUB_B) && tail_zero)
                        mob_flag = 1'b1;
                end
                MOB_CANCEL_ID:
                begin
                    if (frame_buf[1] == ZERO_BYTE && frame_buf[2] == MOB_CANCEL_ARG)
                        mob_flag = 1'b0;
                end
                RADAR_ID_A, RADAR_ID_B:
                begin
                    if ((frame_buf[1] == RADAR_SUB_A || frame_buf[1] == RADAR_SUB_B) &&
                        frame_buf[2] == RADAR_ARG && frame_buf[3] == ZERO_BYTE &&
                        frame_buf[4] == ZERO_BYTE)
                    begin
                        if (frame_buf[5] == RADAR_ON_CODE)
                        begin
                            radar_flag = 1'b1;
                            snooze     = 1'b1;
                        end
                        if (frame_buf[5] == RADAR_OFF_CODE)
                            radar_flag = 1'b0;
                    end
                end
                WIND_ID:
                begin
                    if (frame_buf[1] == ZERO_BYTE)
                    begin
                        if (frame_buf[2] == ZERO_BYTE)
                            wind_flag = 1'b0;
                        else
                        begin
                            wind_flag = 1'b1;
                            snooze    = 1'b1;
                        end
                    end
                end
                default:
                    ;
            endcase
            return snooze;
        end
    endfunction

    task automatic decode_char(input in_item_t item);
        out_item_t res;
        begin
            res = '0;
            if (item.command_flag)
            begin
                res.snooze_clear  = match_datagram();
                res.datagram_done = 1'b1;
                wr_pos = 0;
            end
            // write position sticks at the last slot on long datagrams
            frame_buf[wr_pos] = item.rx_byte;
            if (wr_pos < BUFFER_DEPTH - 1)
                wr_pos++;
            res.mob_alarm   = mob_flag;
            res.wind_alarm  = wind_flag;
            res.radar_alarm = radar_flag;
            expected_alarms_q.push_back(res);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BUFFER_DEPTH; i++)
                frame_buf[i] = ZERO_BYTE;
            wr_pos     = 0;
            mob_flag   = 1'b0;
            wind_flag  = 1'b0;
            radar_flag = 1'b0;
            expected_alarms_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_alarms_q.size() == 0)
                    report_mismatch("result with no item outstanding");
                else
                begin
                    out_item_t want;
                    want = expected_alarms_q.pop_front();
                    check_flag("mob_alarm", out_data.mob_alarm, want.mob_alarm);
                    check_flag("wind_alarm", out_data.wind_alarm, want.wind_alarm);
                    check_flag("radar_alarm", out_data.radar_alarm, want.radar_alarm);
                    check_flag("snooze_clear", out_data.snooze_clear, want.snooze_clear);
                    check_flag("datagram_done", out_data.datagram_done, want.datagram_done);
                end
            end
            if (in_valid && !in_stall)
                decode_char(in_data);
        end
    end

endmodule

>>> tb/nine_bit_alarm_datagram_decoder_top_tb.sv
// Testbench top for the alarm datagram decoder: clock, reset, stimulus and verdict.
module nine_bit_alarm_datagram_decoder_top_tb;
    import nbad_pkg::*;

    localparam int DEPTH      = 20;
    localparam int NUM_ITEMS  = 800;
    localparam int CALM_AFTER = 680;
    localparam int STALL_LIMIT = 1000;

    typedef enum int
    {
        FR_MOB_ON,
        FR_RADAR_ON,
        FR_WIND_ON,
        FR_MOB_CANCEL,
        FR_RADAR_OFF,
        FR_WIND_OFF,
        FR_RADAR_ODD,
        FR_NOISE
    } frame_kind_e;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;
    int        fail_count;
    int        pending;

    int         idle_pct = 0;
    int         items_sent = 0;
    int         stall_left = 0;
    int         quiet_cycles = 0;
    logic [7:0] frame_bytes [32];
    int         frame_len;

    nine_bit_alarm_datagram_decoder_top #(.BUFFER_DEPTH(DEPTH)) uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    nine_bit_alarm_datagram_decoder_checker #(.BUFFER_DEPTH(DEPTH)) alarm_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side backpressure, in random bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 4);
        end
        else
            out_stall <= 1'b0;
    end

    // watchdog: cycles with no item moving on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_char(input logic [7:0] data, input logic cmd);
        in_item_t item;
        int       gap;
        begin
            item.rx_byte      = data;
            item.command_flag = cmd;
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                in_valid <= 1'b0;
                gap = $urandom_range(1, 5);
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= item;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            items_sent++;
        end
    endtask

    task automatic send_frame();
        int i;
        begin
            for (i = 0; i < frame_len; i++)
                send_char(frame_bytes[i], i == 0);
        end
    endtask

    task automatic build_frame(input frame_kind_e kind);
        int i;
        begin
            case (kind)
                FR_MOB_ON:
                begin
                    frame_bytes[0] = MOB_ON_ID;
                    frame_bytes[1] = $urandom_range(0, 1) ? MOB_ON_SUB_A : MOB_ON_SUB_B;
                    for (i = 2; i < HEAD_LEN; i++)
                        frame_bytes[i] = ZERO_BYTE;
                    // short form relies on stale zeros in slots 2..9
                    frame_len = $urandom_range(0, 1) ? 2 : HEAD_LEN;
                end
                FR_MOB_CANCEL:
                begin
                    frame_bytes[0] = MOB_CANCEL_ID;
                    frame_bytes[1] = ZERO_BYTE;
                    frame_bytes[2] = MOB_CANCEL_ARG;
                    frame_len = 3;
                end
                FR_RADAR_ON, FR_RADAR_OFF, FR_RADAR_ODD:
                begin
                    frame_bytes[0] = $urandom_range(0, 1) ? RADAR_ID_A : RADAR_ID_B;
                    frame_bytes[1] = $urandom_range(0, 1) ? RADAR_SUB_A : RADAR_SUB_B;
                    frame_bytes[2] = RADAR_ARG;
                    frame_bytes[3] = ZERO_BYTE;
                    frame_bytes[4] = ZERO_BYTE;
                    if (kind == FR_RADAR_ON)
                        frame_bytes[5] = RADAR_ON_CODE;
                    else if (kind == FR_RADAR_OFF)
                        frame_bytes[5] = RADAR_OFF_CODE;
                    else
                        frame_bytes[5] = 8'($urandom_range(0, 255));
                    frame_len = 6;
                end
                FR_WIND_ON, FR_WIND_OFF:
                begin
                    frame_bytes[0] = WIND_ID;
                    frame_bytes[1] = ZERO_BYTE;
                    frame_bytes[2] = (kind == FR_WIND_ON) ? 8'($urandom_range(1, 255)) : ZERO_BYTE;
                    frame_len = 3;
                end
                default:
                begin
                    // noise; lengths past the buffer depth exercise the saturated slot
                    frame_len = $urandom_range(1, 26);
                    for (i = 0; i < frame_len; i++)
                        frame_bytes[i] = 8'($urandom_range(0, 255));
                end
            endcase
        end
    endtask

    initial
    begin
        int          i;
        int          k;
        int          new_len;
        frame_kind_e kind;
        int          pct_by_phase [3];

        pct_by_phase = '{15, 0, 40};
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: first command on an all-zero buffer, then each pattern once
        idle_pct = 20;
        send_char(ZERO_BYTE, 1'b1);
        for (k = FR_MOB_ON; k <= FR_WIND_OFF; k++)
        begin
            build_frame(frame_kind_e'(k));
            if (k == FR_MOB_ON)
                frame_len = 2;
            send_frame();
        end
        send_char(8'hFF, 1'b1);

        while (items_sent < NUM_ITEMS)
        begin
            idle_pct = (items_sent >= CALM_AFTER) ? 0 : pct_by_phase[(items_sent / 100) % 3];
            kind = frame_kind_e'($urandom_range(FR_MOB_ON, FR_NOISE));
            build_frame(kind);
            if (kind != FR_NOISE && $urandom_range(0, 3) == 0)
            begin
                // near miss: one flipped bit somewhere in the datagram
                i = $urandom_range(0, frame_len - 1);
                frame_bytes[i] ^= 8'(1 << $urandom_range(0, 7));
            end
            if (kind != FR_NOISE && $urandom_range(0, 4) == 0)
            begin
                // zero-padded head plus trailing bytes, may run past the buffer
                new_len = HEAD_LEN + $urandom_range(1, 16);
                for (i = frame_len; i < HEAD_LEN; i++)
                    frame_bytes[i] = ZERO_BYTE;
                for (i = HEAD_LEN; i < new_len; i++)
                    frame_bytes[i] = 8'($urandom_range(0, 255));
                frame_len = new_len;
            end
            send_frame();
        end
        // one more command so the last datagram gets evaluated
        send_char(8'($urandom_range(0, 255)), 1'b1);
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
